### src/ptmx_pkg.sv
// shared types and constants for the persistent trie max xor block
package ptmx_pkg;

	localparam int KEY_BITS_DEF     = 31;
	localparam int MAX_VERSIONS_DEF = 1024;
	localparam int NODE_POOL_DEF    = 65536;

	localparam int VAL_W = 31;
	localparam int VER_W = 11;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic FUNC_APPEND = 1'b0;
	localparam logic FUNC_QUERY  = 1'b1;

	typedef struct packed {
		logic             func;
		logic [VAL_W-1:0] value;
		logic [VER_W-1:0] lo_version;
		logic [VER_W-1:0] hi_version;
	} in_word_t;

	typedef struct packed {
		logic [VAL_W-1:0] max_xor;
		logic [VER_W-1:0] version;
		logic             found;
		logic [1:0]       status;
	} out_word_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_ROOT,
		BK_READ,
		BK_STEP,
		BK_DONE
	} bk_state_t;

endpackage

### src/ptmx_queue.sv
// small two-entry queue between the front and back parts
module ptmx_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ptmx_pkg::in_word_t  push_data,
	output logic                full,
	input  logic                pop,
	output ptmx_pkg::in_word_t  pop_data,
	output logic                empty
);

	ptmx_pkg::in_word_t mem_q [2];
	logic               wp_q;
	logic               rp_q;
	logic [1:0]         cnt_q;

	assign full     = cnt_q == 2'd2;
	assign empty    = cnt_q == 2'd0;
	assign pop_data = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wp_q] <= push_data;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) wp_q <= ~wp_q;
			if (pop && !empty) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push && !full) - 2'(pop && !empty);
		end
	end

endmodule

### src/ptmx_back.sv
// trie engine: append path copy and range max xor walk, one level per step
module ptmx_back #(
	parameter int KEY_BITS     = ptmx_pkg::KEY_BITS_DEF,
	parameter int MAX_VERSIONS = ptmx_pkg::MAX_VERSIONS_DEF,
	parameter int NODE_POOL    = ptmx_pkg::NODE_POOL_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  ptmx_pkg::in_word_t    in_data,
	output logic                  in_take,
	output logic                  out_valid,
	output ptmx_pkg::out_word_t   out_data,
	input  logic                  out_take
);

	localparam int NW = $clog2(NODE_POOL);
	localparam int VW = $clog2(MAX_VERSIONS + 1);
	localparam int PW = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
	localparam int CW = ptmx_pkg::VER_W;

	// node memories
	logic [CW-1:0] cnt0_mem [NODE_POOL];
	logic [CW-1:0] cnt1_mem [NODE_POOL];
	logic [NW-1:0] ch0_mem  [NODE_POOL];
	logic [NW-1:0] ch1_mem  [NODE_POOL];
	logic [NW-1:0] root_mem [MAX_VERSIONS+1];

	ptmx_pkg::bk_state_t state_q, state_d;
	logic [NW:0]   nodes_q;
	logic [VW-1:0] vers_q;
	ptmx_pkg::in_word_t item_q;
	logic [PW-1:0] pos_q;
	logic [NW-1:0] a_q, c_q, cur_q;
	logic          a_zero_q, c_zero_q;
	logic [ptmx_pkg::VAL_W-1:0] best_q;
	logic          wait_q;

	// registered read data for nodes a (prev) and c
	logic [CW-1:0] a_c0, a_c1, c_c0, c_c1;
	logic [NW-1:0] a_h0, a_h1, c_h0, c_h1;
	logic [NW-1:0] root_a, root_c;

	logic bit_k, op_b;
	logic [CW-1:0] ea0, ea1, ec0, ec1;
	logic [NW-1:0] ha0, ha1, hc0, hc1;
	logic          take_o;
	logic [NW-1:0] nxt_a, nxt_c;
	logic          append_ok, range_bad;

	assign bit_k = item_q.value[pos_q];
	assign op_b  = ~bit_k;
	// node zero reads as the empty node
	assign ea0 = a_zero_q ? '0 : a_c0;
	assign ea1 = a_zero_q ? '0 : a_c1;
	assign ec0 = c_zero_q ? '0 : c_c0;
	assign ec1 = c_zero_q ? '0 : c_c1;
	assign ha0 = a_zero_q ? '0 : a_h0;
	assign ha1 = a_zero_q ? '0 : a_h1;
	assign hc0 = c_zero_q ? '0 : c_h0;
	assign hc1 = c_zero_q ? '0 : c_h1;

	assign take_o = op_b ? (ec1 > ea1) : (ec0 > ea0);
	assign nxt_a  = (take_o ? op_b : bit_k) ? ha1 : ha0;
	assign nxt_c  = (take_o ? op_b : bit_k) ? hc1 : hc0;

	assign append_ok = (32'(vers_q) < MAX_VERSIONS) &&
		(33'(nodes_q) + 33'(KEY_BITS) <= 33'(NODE_POOL - 1));
	assign range_bad = (in_data.lo_version > in_data.hi_version) ||
		(32'(in_data.hi_version) > 32'(vers_q));

	// memory reads, registered
	always_ff @(posedge clk) begin
		a_c0   <= cnt0_mem[a_q];
		a_c1   <= cnt1_mem[a_q];
		a_h0   <= ch0_mem[a_q];
		a_h1   <= ch1_mem[a_q];
		c_c0   <= cnt0_mem[c_q];
		c_c1   <= cnt1_mem[c_q];
		c_h0   <= ch0_mem[c_q];
		c_h1   <= ch1_mem[c_q];
		root_a <= root_mem[item_q.func ? VW'(item_q.lo_version) : vers_q];
		root_c <= root_mem[VW'(item_q.hi_version)];
	end

	// append writes one node per level
	always_ff @(posedge clk) begin
		if (state_q == ptmx_pkg::BK_ROOT && item_q.func == ptmx_pkg::FUNC_APPEND)
			root_mem[vers_q + VW'(1)] <= nodes_q[NW-1:0] + NW'(1);
		if (state_q == ptmx_pkg::BK_STEP && !wait_q &&
			item_q.func == ptmx_pkg::FUNC_APPEND) begin
			cnt0_mem[cur_q] <= bit_k ? ea0 : ea0 + CW'(1);
			cnt1_mem[cur_q] <= bit_k ? ea1 + CW'(1) : ea1;
			ch0_mem[cur_q]  <= bit_k ? ha0 : ((pos_q == '0) ? '0 : cur_q + NW'(1));
			ch1_mem[cur_q]  <= bit_k ? ((pos_q == '0) ? '0 : cur_q + NW'(1)) : ha1;
		end
	end

	// root zero is the empty trie
	logic ra_zero, rc_zero;
	assign ra_zero = item_q.func ? (item_q.lo_version == '0) : (vers_q == '0);
	assign rc_zero = item_q.hi_version == '0;

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptmx_pkg::BK_IDLE;
			nodes_q <= '0;
			vers_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ptmx_pkg::BK_STEP && !wait_q &&
				item_q.func == ptmx_pkg::FUNC_APPEND) begin
				nodes_q <= nodes_q + (NW+1)'(1);
				if (pos_q == '0) vers_q <= vers_q + VW'(1);
			end
		end
	end

	// item datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ptmx_pkg::BK_IDLE: begin
				if (in_valid) begin
					item_q <= in_data;
					best_q <= '0;
					pos_q  <= PW'(KEY_BITS - 1);
					out_data.max_xor <= '0;
					out_data.found   <= 1'b0;
					out_data.version <= CW'(vers_q);
					if (in_data.func == ptmx_pkg::FUNC_APPEND && !append_ok)
						out_data.status <= ptmx_pkg::ST_FULL;
					else if (in_data.func == ptmx_pkg::FUNC_QUERY && range_bad)
						out_data.status <= ptmx_pkg::ST_RANGE;
					else
						out_data.status <= ptmx_pkg::ST_OK;
				end
			end
			ptmx_pkg::BK_ROOT: begin
				cur_q <= nodes_q[NW-1:0] + NW'(1);
			end
			ptmx_pkg::BK_READ: begin
				a_q      <= root_a;
				c_q      <= root_c;
				a_zero_q <= ra_zero || root_a == '0;
				c_zero_q <= rc_zero || root_c == '0;
			end
			ptmx_pkg::BK_STEP: begin
				if (!wait_q) begin
					if (item_q.func == ptmx_pkg::FUNC_QUERY) begin
						a_q <= nxt_a;
						c_q <= nxt_c;
						a_zero_q <= nxt_a == '0;
						c_zero_q <= nxt_c == '0;
						if (take_o) best_q[pos_q] <= 1'b1;
					end else begin
						a_q <= bit_k ? ha1 : ha0;
						a_zero_q <= (bit_k ? ha1 : ha0) == '0;
						cur_q <= cur_q + NW'(1);
					end
					pos_q <= pos_q - PW'(1);
					if (pos_q == '0) begin
						if (item_q.func == ptmx_pkg::FUNC_QUERY) begin
							out_data.max_xor <= take_o ? (best_q | (ptmx_pkg::VAL_W'(1) << pos_q)) : best_q;
							out_data.found   <= 1'b1;
						end else begin
							out_data.version <= CW'(vers_q + VW'(1));
						end
					end
				end
			end
			default: ;
		endcase
	end

	// the step state waits on wait_q for the registered reads between levels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) wait_q <= 1'b0;
		else wait_q <= (state_d == ptmx_pkg::BK_STEP) && !wait_q;
	end

	// next state
	always_comb begin
		state_d   = state_q;
		in_take   = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ptmx_pkg::BK_IDLE: begin
				in_take = in_valid;
				if (in_valid) begin
					if (in_data.func == ptmx_pkg::FUNC_APPEND)
						state_d = append_ok ? ptmx_pkg::BK_ROOT : ptmx_pkg::BK_DONE;
					else if (range_bad || in_data.lo_version == in_data.hi_version)
						state_d = ptmx_pkg::BK_DONE;
					else
						state_d = ptmx_pkg::BK_ROOT;
				end
			end
			ptmx_pkg::BK_ROOT: state_d = ptmx_pkg::BK_READ;
			ptmx_pkg::BK_READ: state_d = ptmx_pkg::BK_STEP;
			ptmx_pkg::BK_STEP: begin
				if (wait_q) state_d = ptmx_pkg::BK_STEP;
				else if (pos_q == '0) state_d = ptmx_pkg::BK_DONE;
				else state_d = ptmx_pkg::BK_STEP;
			end
			ptmx_pkg::BK_DONE: begin
				out_valid = 1'b1;
				if (out_take) state_d = ptmx_pkg::BK_IDLE;
			end
			default: state_d = ptmx_pkg::BK_IDLE;
		endcase
	end

endmodule

### src/persistent_trie_max_xor_top.sv
// top level: input queue, trie engine and output register
// items run one at a time: a new one is taken only after the last result leaves
// bad or empty items skip the trie walk and go straight to the done state
// each trie level waits for the registered node memory reads of the level before
// reset: asynchronous, active low; clears queue, counts and state, no memory pass
module persistent_trie_max_xor_top #(
	parameter int KEY_BITS     = ptmx_pkg::KEY_BITS_DEF,
	parameter int MAX_VERSIONS = ptmx_pkg::MAX_VERSIONS_DEF,
	parameter int NODE_POOL    = ptmx_pkg::NODE_POOL_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ptmx_pkg::in_word_t  in_word,
	output logic                full,
	input  logic                pop,
	output ptmx_pkg::out_word_t out_word,
	output logic                empty
);

	ptmx_pkg::in_word_t  q_data;
	logic                q_empty, q_pop;
	logic                bk_valid, bk_take;
	ptmx_pkg::out_word_t bk_data;
	logic                out_v_q;

	// front queue
	ptmx_queue u_queue (
		.clk, .arst_n, .push, .push_data(in_word), .full,
		.pop(q_pop), .pop_data(q_data), .empty(q_empty)
	);

	// back engine
	ptmx_back #(.KEY_BITS(KEY_BITS), .MAX_VERSIONS(MAX_VERSIONS), .NODE_POOL(NODE_POOL)) u_back (
		.clk, .arst_n, .in_valid(!q_empty), .in_data(q_data), .in_take(q_pop),
		.out_valid(bk_valid), .out_data(bk_data), .out_take(bk_take)
	);

	// output register
	assign bk_take = bk_valid && (!out_v_q || pop);
	assign empty   = !out_v_q;
	always_ff @(posedge clk) begin
		if (bk_take) out_word <= bk_data;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (bk_take) out_v_q <= 1'b1;
		else if (pop) out_v_q <= 1'b0;
	end

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && out_word.found |-> out_word.status == ptmx_pkg::ST_OK)
		else $error("found with error status");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && out_word.status != ptmx_pkg::ST_OK |-> out_word.max_xor == '0)
		else $error("error result carries data");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_word))
		else $error("result lost");

endmodule
